@@ rtl/gcr_pkg.sv @@
// Shared types, constants, code mapping and the 5x7 font table for the glyph column renderer.
// No dependencies; every other file of the block imports this package.
package gcr_pkg;

  // Coordinate port width and default configuration
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned GLYPH_COUNT_DEF = 100;
  localparam int unsigned ROM_GLYPHS     = 100;
  localparam int unsigned NUM_COLS       = 5;
  localparam int unsigned NUM_SLOTS      = NUM_COLS + 1;
  localparam int unsigned ULINE_SLOT     = NUM_COLS;

  // Font mode bits
  localparam int unsigned MODE_FIXED = 0;
  localparam int unsigned MODE_ULINE = 1;

  // First printable code, mapped to glyph 0
  localparam logic [7:0] CODE_BASE = 8'd32;

  // Latin-1 codes that fold onto the extra glyph slots
  localparam logic [7:0] CODE_A_UML_UC = 8'd196;
  localparam logic [7:0] CODE_O_UML_UC = 8'd214;
  localparam logic [7:0] CODE_O_UML_LC = 8'd246;
  localparam logic [7:0] CODE_U_UML_UC = 8'd220;
  localparam logic [7:0] CODE_U_UML_LC = 8'd252;
  localparam logic [7:0] CODE_A_UML_LC = 8'd228;
  localparam logic [7:0] CODE_SHARP_S  = 8'd223;

  localparam logic [7:0] SLOT_A_UML_UC = 8'd127;
  localparam logic [7:0] SLOT_O_UML    = 8'd128;
  localparam logic [7:0] SLOT_U_UML    = 8'd129;
  localparam logic [7:0] SLOT_A_UML_LC = 8'd130;
  localparam logic [7:0] SLOT_SHARP_S  = 8'd131;

  // Pixel patterns of a column write
  localparam logic [6:0] GLYPH_ROWS = 7'h7F;
  localparam logic [7:0] ULINE_BIT  = 8'h80;

  // Glyph fetched from the font, one byte per column, column 0 at index 0
  typedef struct packed {
    logic                          glyph_ok;
    logic [1:0]                    mode;
    logic [COORD_W-1:0]            px;
    logic [COORD_W-1:0]            py;
    logic [NUM_COLS-1:0][7:0]      cols;
  } glyph_t;

  // One pending column or underline write
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [7:0]         bits;
    logic [7:0]         mask;
    logic [2:0]         width;
  } slot_t;

  // All writes of one character, with a pending bit per slot
  typedef struct packed {
    logic [COORD_W-1:0]               py;
    logic [NUM_SLOTS-1:0]             pend;
    logic [NUM_SLOTS-1:0][$bits(slot_t)-1:0] slot;
  } burst_t;

  // Fold umlauts and sharp s onto the extra glyph codes
  function automatic logic [7:0] map_code(input logic [7:0] code);
    logic [7:0] res;
    res = code;
    case (code)
      CODE_A_UML_UC:                 res = SLOT_A_UML_UC;
      CODE_O_UML_UC, CODE_O_UML_LC:  res = SLOT_O_UML;
      CODE_U_UML_UC, CODE_U_UML_LC:  res = SLOT_U_UML;
      CODE_A_UML_LC:                 res = SLOT_A_UML_LC;
      CODE_SHARP_S:                  res = SLOT_SHARP_S;
      default:                       res = code;
    endcase
    return res;
  endfunction

  // Font table: column 0 in the top byte, column 4 in the low byte
  localparam logic [39:0] GLYPH_ROM [ROM_GLYPHS] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_03_00_03_00,
    40'h14_7F_14_7F_14, 40'h24_2A_7F_2A_12, 40'h26_16_08_34_32,
    40'h36_49_55_22_50, 40'h00_00_03_00_00, 40'h00_1C_22_41_00,
    40'h00_41_22_1C_00, 40'h22_14_7F_14_22, 40'h08_08_3E_08_08,
    40'h00_00_60_30_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00,
    40'h20_10_08_04_02, 40'h3E_41_41_41_3E, 40'h00_42_7F_40_00,
    40'h42_61_51_49_46, 40'h22_41_49_49_36, 40'h0C_0A_49_7F_48,
    40'h2F_49_49_49_31, 40'h3E_49_49_49_32, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h26_49_49_49_3E, 40'h00_00_36_36_00,
    40'h00_00_56_36_00, 40'h08_14_22_41_00, 40'h14_14_14_14_14,
    40'h41_22_14_08_00, 40'h02_01_51_09_06, 40'h3E_41_5D_55_1E,
    40'h7E_09_09_09_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_41_3E, 40'h7F_49_49_49_41, 40'h7F_09_09_09_09,
    40'h3E_41_49_49_3A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
    40'h30_40_41_3F_01, 40'h7F_08_08_14_63, 40'h00_7F_40_40_40,
    40'h7F_04_08_04_7F, 40'h7F_02_0C_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_61_7E, 40'h7F_09_19_29_46,
    40'h26_49_49_49_32, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
    40'h07_18_60_18_07, 40'h1F_60_18_60_1F, 40'h63_14_08_14_63,
    40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04,
    40'h40_40_40_40_40, 40'h00_01_02_00_00, 40'h30_4A_4A_4A_7C,
    40'h00_7F_44_44_38, 40'h38_44_44_44_00, 40'h00_38_44_44_7F,
    40'h38_54_54_54_18, 40'h08_7E_09_01_00, 40'h0C_52_52_52_3C,
    40'h7F_04_04_04_78, 40'h00_00_7A_00_00, 40'h20_40_3A_00_00,
    40'h7F_10_28_44_00, 40'h00_00_7F_00_00, 40'h7C_04_18_04_78,
    40'h00_78_04_04_78, 40'h38_44_44_44_38, 40'h7C_14_24_24_18,
    40'h18_24_24_14_7C, 40'h7C_08_04_04_00, 40'h48_54_54_54_24,
    40'h00_02_3F_42_00, 40'h3C_40_40_40_3C, 40'h1C_20_40_20_1C,
    40'h3C_40_30_40_3C, 40'h44_28_10_28_44, 40'h0C_50_50_50_3C,
    40'h44_64_54_4C_00, 40'h08_36_41_41_00, 40'h00_00_7F_00_00,
    40'h41_41_36_08_00, 40'h08_04_08_10_08,
    40'h79_14_12_14_79, 40'h39_44_44_44_39, 40'h3D_40_40_40_3D,
    40'h31_48_48_48_7D, 40'h7E_01_49_49_36
  };

endpackage

@@ rtl/glyph_column_renderer_5x7.sv @@
// Top level of the 5x7 glyph column renderer: fetch, shape and emit stages.
// Depends on gcr_pkg, gcr_fetch, gcr_shape and gcr_emit.
//
// A character request is taken when start_i is high and busy_o is low. It
// passes four register stages (code mapping, font read, thinning and width,
// coordinates and limit check) and then a sequencer that drives one write per
// cycle on the result ports, strobed by result_valid_o for exactly one cycle;
// the receiver cannot stall it. A character gives 1 to 6 writes (one per drawn
// column plus the underline pixel), and the sequencer sets the sustained rate.
// The next request may enter while the previous one is still being written.
// When the output is free, a request passes from the fourth stage straight
// into the sequencer register and its first write is on the result ports.
// busy_o rises only while the stages are backed up behind the sequencer.
module glyph_column_renderer_5x7 import gcr_pkg::*; #(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         char_code_i,
  input  logic [1:0]         font_mode_i,
  input  logic [COORD_W-1:0] pos_x_i,
  input  logic [COORD_W-1:0] pos_y_i,
  output logic               result_valid_o,
  output logic [COORD_W-1:0] column_x_o,
  output logic [COORD_W-1:0] top_y_o,
  output logic [7:0]         row_bits_o,
  output logic [7:0]         row_write_mask_o,
  output logic               last_o,
  output logic [2:0]         char_width_o
);

  logic   fetch_ready;
  logic   glyph_valid, shape_ready;
  glyph_t glyph;
  logic   burst_valid, emit_ready;
  burst_t burst;

  assign busy_o = !fetch_ready;

  // Map the code and read the font
  gcr_fetch #(
    .COORD_BITS  (COORD_BITS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_fetch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i),
    .in_ready_o  (fetch_ready),
    .char_code_i (char_code_i),
    .font_mode_i (font_mode_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .out_valid_o (glyph_valid),
    .out_ready_i (shape_ready),
    .out_o       (glyph)
  );

  // Thin columns and lay out the writes
  gcr_shape #(
    .COORD_BITS (COORD_BITS)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (glyph_valid),
    .in_ready_o  (shape_ready),
    .in_i        (glyph),
    .out_valid_o (burst_valid),
    .out_ready_i (emit_ready),
    .out_o       (burst)
  );

  // Issue the writes one per cycle
  gcr_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (burst_valid),
    .in_ready_o       (emit_ready),
    .in_i             (burst),
    .result_valid_o   (result_valid_o),
    .column_x_o       (column_x_o),
    .top_y_o          (top_y_o),
    .row_bits_o       (row_bits_o),
    .row_write_mask_o (row_write_mask_o),
    .last_o           (last_o),
    .char_width_o     (char_width_o)
  );

endmodule

@@ rtl/gcr_fetch.sv @@
// Front stages: code mapping and glyph range check, then the font table read.
// Depends on gcr_pkg.
module gcr_fetch import gcr_pkg::*; #(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_code_i,
  input  logic [1:0]         font_mode_i,
  input  logic [COORD_W-1:0] pos_x_i,
  input  logic [COORD_W-1:0] pos_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output glyph_t             out_o
);

  localparam logic [COORD_W-1:0] CMASK = COORD_W'((32'd1 << COORD_BITS) - 32'd1);

  logic               v1_q, v2_q;
  logic               en1, en2;
  logic [7:0]         idx;
  logic [6:0]         idx1_q;
  logic               ok1_q;
  logic [1:0]         mode1_q;
  logic [COORD_W-1:0] px1_q, py1_q;
  logic [39:0]        entry;
  glyph_t             glyph_d, glyph_q;

  // Stage enables: a stage takes new data when empty or draining
  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Map the code and find the glyph index
  assign idx = map_code(char_code_i) - CODE_BASE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      idx1_q  <= idx[6:0];
      ok1_q   <= (idx < 8'(GLYPH_COUNT));
      mode1_q <= font_mode_i;
      px1_q   <= pos_x_i & CMASK;
      py1_q   <= pos_y_i & CMASK;
    end
  end

  // Read the font table for valid glyphs only
  assign entry = ok1_q ? GLYPH_ROM[idx1_q] : '0;

  always_comb begin
    glyph_d          = '0;
    glyph_d.glyph_ok = ok1_q;
    glyph_d.mode     = mode1_q;
    glyph_d.px       = px1_q;
    glyph_d.py       = py1_q;
    for (int i = 0; i < NUM_COLS; i++) begin
      glyph_d.cols[i] = entry[39 - 8*i -: 8];
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      glyph_q <= glyph_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = glyph_q;

endmodule

@@ rtl/gcr_shape.sv @@
// Middle stages: column thinning and width prefix, then coordinates, limit check
// and the per-slot write list. Depends on gcr_pkg.
module gcr_shape import gcr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  glyph_t in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output burst_t out_o
);

  localparam logic [COORD_W-1:0] CMASK = COORD_W'((32'd1 << COORD_BITS) - 32'd1);

  logic                     v3_q, v4_q;
  logic                     en3, en4;
  logic                     thin;
  logic [2:0]               run;
  logic [NUM_COLS-1:0][7:0] tcol;
  logic [NUM_COLS-1:0]      nz;
  logic [NUM_SLOTS-1:0][2:0] wb;

  logic                      ok3_q;
  logic                      ul3_q;
  logic [COORD_W-1:0]        px3_q, py3_q;
  logic [NUM_COLS-1:0][7:0]  col3_q;
  logic [NUM_SLOTS-1:0][2:0] wb3_q;

  logic [NUM_SLOTS-1:0][COORD_W:0] sum;
  logic [NUM_COLS-1:0]       draw;
  logic [COORD_W:0]          fin_sum;
  logic [2:0]                fin_w;
  slot_t                     sl;
  burst_t                    burst_d, burst_q;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign in_ready_o = en3;

  // Blank repeated columns in proportional mode
  assign thin = !in_i.mode[MODE_FIXED];

  always_comb begin
    run  = '0;
    tcol = in_i.cols;
    for (int i = 0; i < NUM_COLS - 1; i++) begin
      run = run + 3'd1;
      if (in_i.cols[i] != in_i.cols[i+1]) run = '0;
      if (thin && (run == 3'd2 || run == 3'd4)) tcol[i] = '0;
    end
  end

  // Count drawn width before each column
  always_comb begin
    wb[0] = '0;
    for (int i = 0; i < NUM_COLS; i++) begin
      nz[i]   = (tcol[i] != '0) || !thin;
      wb[i+1] = wb[i] + {2'b00, nz[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= in_valid_i;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 3 payload
  always_ff @(posedge clk_i) begin
    if (en3 && in_valid_i) begin
      ok3_q  <= in_i.glyph_ok;
      ul3_q  <= in_i.mode[MODE_ULINE];
      px3_q  <= in_i.px;
      py3_q  <= in_i.py;
      col3_q <= tcol;
      wb3_q  <= wb;
    end
  end

  // Column positions and limit check; a column past the limit stops drawing
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sum[i] = (COORD_W+1)'(px3_q) + (COORD_W+1)'(wb3_q[i]);
    end
    for (int i = 0; i < NUM_COLS; i++) begin
      if (i == 0) draw[i] = !sum[i][COORD_BITS];
      else        draw[i] = !sum[i][COORD_BITS] && draw[i-1];
    end
    fin_sum = sum[NUM_SLOTS-1];
    fin_w   = wb3_q[NUM_SLOTS-1];
    for (int i = NUM_COLS - 1; i >= 0; i--) begin
      if (!draw[i]) begin
        fin_sum = sum[i];
        fin_w   = wb3_q[i];
      end
    end
  end

  // Build the write list for the sequencer
  always_comb begin
    burst_d    = '0;
    burst_d.py = py3_q;
    sl         = '0;
    if (ok3_q) begin
      for (int i = 0; i < NUM_COLS; i++) begin
        sl.x     = sum[i][COORD_W-1:0] & CMASK;
        sl.bits  = {ul3_q, col3_q[i][6:0]};
        sl.mask  = {ul3_q, GLYPH_ROWS};
        sl.width = wb3_q[i+1];
        burst_d.slot[i] = sl;
        burst_d.pend[i] = draw[i];
      end
      sl.x     = fin_sum[COORD_W-1:0] & CMASK;
      sl.bits  = ULINE_BIT;
      sl.mask  = ULINE_BIT;
      sl.width = fin_w;
      burst_d.slot[ULINE_SLOT] = sl;
      burst_d.pend[ULINE_SLOT] = ul3_q;
    end else begin
      // Code outside the font: one empty write at the origin
      sl.x            = px3_q;
      burst_d.slot[0] = sl;
      burst_d.pend[0] = 1'b1;
    end
  end

  // Stage 4 payload
  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      burst_q <= burst_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = burst_q;

endmodule

@@ rtl/gcr_emit.sv @@
// Result sequencer: issues the pending writes of one character, one per cycle,
// lowest slot first, and flags the final one. Depends on gcr_pkg.
module gcr_emit import gcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  burst_t             in_i,
  output logic               result_valid_o,
  output logic [COORD_W-1:0] column_x_o,
  output logic [COORD_W-1:0] top_y_o,
  output logic [7:0]         row_bits_o,
  output logic [7:0]         row_write_mask_o,
  output logic               last_o,
  output logic [2:0]         char_width_o
);

  logic [NUM_SLOTS-1:0] pend_q;
  logic [NUM_SLOTS-1:0] pick;
  logic                 last;
  logic                 free;
  burst_t               burst_q;
  slot_t                cur;

  // Pick the lowest pending slot
  always_comb begin
    pick = '0;
    cur  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        pick = NUM_SLOTS'(1) << i;
        cur  = burst_q.slot[i];
      end
    end
  end

  assign last       = ((pend_q & ~pick) == '0);
  assign free       = (pend_q == '0) || last;
  assign in_ready_o = free;

  // Load a new character when idle or when the last write goes out, else drop the issued slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (free) begin
      pend_q <= in_valid_i ? in_i.pend : '0;
    end else begin
      pend_q <= pend_q & ~pick;
    end
  end

  // Hold the write list
  always_ff @(posedge clk_i) begin
    if (free && in_valid_i) begin
      burst_q <= in_i;
    end
  end

  assign result_valid_o   = (pend_q != '0);
  assign column_x_o       = cur.x;
  assign top_y_o          = burst_q.py;
  assign row_bits_o       = cur.bits;
  assign row_write_mask_o = cur.mask;
  assign last_o           = last;
  assign char_width_o     = cur.width;

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for glyph_column_renderer_5x7: directed and random character requests.
// Depends on gcr_pkg (port widths, fold codes, mode bit positions) and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import gcr_pkg::*;

  // Font modes as the request encodes them
  localparam logic [1:0] FM_PROP     = 2'b00;
  localparam logic [1:0] FM_FIXED    = 2'b01;
  localparam logic [1:0] FM_PROP_UL  = 2'b10;
  localparam logic [1:0] FM_FIXED_UL = 2'b11;

  // Character codes used by the directed part
  localparam logic [7:0] CH_BELOW_FONT = 8'd31;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_EXCL       = 8'd33;
  localparam logic [7:0] CH_DASH       = 8'd45;
  localparam logic [7:0] CH_A          = 8'd65;
  localparam logic [7:0] CH_B          = 8'd66;
  localparam logic [7:0] CH_H          = 8'd72;
  localparam logic [7:0] CH_M          = 8'd77;
  localparam logic [7:0] CH_W          = 8'd87;
  localparam logic [7:0] CH_DEL        = 8'd127;
  localparam logic [7:0] CH_TOP_GLYPH  = 8'd131;
  localparam logic [7:0] CH_PAST_FONT  = 8'd132;

  localparam int FONT_GLYPHS    = 100;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 16;

  localparam logic [7:0] FOLDED_CODES [7] = '{
    CODE_A_UML_UC, CODE_O_UML_UC, CODE_O_UML_LC, CODE_U_UML_UC,
    CODE_U_UML_LC, CODE_A_UML_LC, CODE_SHARP_S
  };

  // 5x7 font, column 0 in the top byte
  localparam logic [39:0] FONT [FONT_GLYPHS] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_03_00_03_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h26_16_08_34_32, 40'h36_49_55_22_50, 40'h00_00_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h22_14_7F_14_22, 40'h08_08_3E_08_08,
    40'h00_00_60_30_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00, 40'h20_10_08_04_02,
    40'h3E_41_41_41_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h22_41_49_49_36,
    40'h0C_0A_49_7F_48, 40'h2F_49_49_49_31, 40'h3E_49_49_49_32, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h26_49_49_49_3E, 40'h00_00_36_36_00, 40'h00_00_56_36_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
    40'h3E_41_5D_55_1E, 40'h7E_09_09_09_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_41_3E, 40'h7F_49_49_49_41, 40'h7F_09_09_09_09, 40'h3E_41_49_49_3A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h30_40_41_3F_01, 40'h7F_08_08_14_63,
    40'h00_7F_40_40_40, 40'h7F_04_08_04_7F, 40'h7F_02_0C_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_61_7E, 40'h7F_09_19_29_46, 40'h26_49_49_49_32,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h07_18_60_18_07, 40'h1F_60_18_60_1F,
    40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_00_00, 40'h30_4A_4A_4A_7C, 40'h00_7F_44_44_38, 40'h38_44_44_44_00,
    40'h00_38_44_44_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_00, 40'h0C_52_52_52_3C,
    40'h7F_04_04_04_78, 40'h00_00_7A_00_00, 40'h20_40_3A_00_00, 40'h7F_10_28_44_00,
    40'h00_00_7F_00_00, 40'h7C_04_18_04_78, 40'h00_78_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_24_24_18, 40'h18_24_24_14_7C, 40'h7C_08_04_04_00, 40'h48_54_54_54_24,
    40'h00_02_3F_42_00, 40'h3C_40_40_40_3C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_00, 40'h08_36_41_41_00,
    40'h00_00_7F_00_00, 40'h41_41_36_08_00, 40'h08_04_08_10_08, 40'h79_14_12_14_79,
    40'h39_44_44_44_39, 40'h3D_40_40_40_3D, 40'h31_48_48_48_7D, 40'h7E_01_49_49_36
  };

  typedef struct packed {
    logic [7:0]         code;
    logic [1:0]         mode;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } glyph_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] column_x;
    logic [COORD_W-1:0] top_y;
    logic [7:0]         row_bits;
    logic [7:0]         row_write_mask;
    logic               last;
    logic [2:0]         char_width;
  } col_write_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic [7:0]         char_code_i = '0;
  logic [1:0]         font_mode_i = '0;
  logic [COORD_W-1:0] pos_x_i     = '0;
  logic [COORD_W-1:0] pos_y_i     = '0;
  logic               busy_o;
  logic               result_valid_o;
  logic [COORD_W-1:0] column_x_o;
  logic [COORD_W-1:0] top_y_o;
  logic [7:0]         row_bits_o;
  logic [7:0]         row_write_mask_o;
  logic               last_o;
  logic [2:0]         char_width_o;

  col_write_t expected_writes [$];
  int         mismatch_count  = 0;
  int         requests_taken  = 0;
  int         writes_checked  = 0;
  int         stall_cycles    = 0;
  bit         gaps_on         = 1'b1;

  glyph_column_renderer_5x7 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .char_code_i     (char_code_i),
    .font_mode_i     (font_mode_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .result_valid_o  (result_valid_o),
    .column_x_o      (column_x_o),
    .top_y_o         (top_y_o),
    .row_bits_o      (row_bits_o),
    .row_write_mask_o(row_write_mask_o),
    .last_o          (last_o),
    .char_width_o    (char_width_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fold umlauts and sharp s onto the extra glyph slots
  function automatic logic [7:0] font_slot(input logic [7:0] code);
    case (code)
      CODE_A_UML_UC:                return SLOT_A_UML_UC;
      CODE_O_UML_UC, CODE_O_UML_LC: return SLOT_O_UML;
      CODE_U_UML_UC, CODE_U_UML_LC: return SLOT_U_UML;
      CODE_A_UML_LC:                return SLOT_A_UML_LC;
      CODE_SHARP_S:                 return SLOT_SHARP_S;
      default:                      return code;
    endcase
  endfunction

  // Work out every column write of one character and queue them
  function automatic void predict_columns(input glyph_req_t req);
    col_write_t burst [6];
    col_write_t w;
    logic [7:0]  idx;
    logic [39:0] glyph;
    logic [7:0]  cols [5];
    logic [16:0] reach;
    bit          thin;
    bit          uline;
    bit          stop;
    int          inc;
    int          run;
    int          width;
    int          n;
    idx   = font_slot(req.code) - CODE_BASE;
    thin  = !req.mode[MODE_FIXED];
    uline = req.mode[MODE_ULINE];
    width = 0;
    n     = 0;
    stop  = 1'b0;
    if (idx >= FONT_GLYPHS) begin
      burst[0] = '{req.px, req.py, 8'h00, 8'h00, 1'b1, 3'd0};
      n = 1;
    end else begin
      glyph = FONT[idx];
      for (int i = 0; i < 5; i++) cols[i] = glyph[39 - 8 * i -: 8];
      // Blank the columns that fall on a run of three or five equal ones
      if (thin) begin
        run = 0;
        for (int i = 0; i < 4; i++) begin
          run++;
          if (cols[i] != cols[i + 1]) run = 0;
          if (run == 2 || run == 4) cols[i] = 8'h00;
        end
      end
      for (int i = 0; i < 5; i++) begin
        if (!stop) begin
          reach = {1'b0, req.px} + 17'(width);
          if (reach[16]) begin
            stop = 1'b1;
          end else begin
            inc = (cols[i] != 8'h00 || !thin) ? 1 : 0;
            width += inc;
            w.column_x       = 16'(int'(req.px) + width - inc);
            w.top_y          = req.py;
            w.row_bits       = {uline, cols[i][6:0]};
            w.row_write_mask = {uline, GLYPH_ROWS};
            w.last           = 1'b0;
            w.char_width     = 3'(width);
            burst[n] = w;
            n++;
          end
        end
      end
      if (uline) begin
        burst[n] = '{16'(int'(req.px) + width), req.py, ULINE_BIT, ULINE_BIT, 1'b1,
                     3'(width)};
        n++;
      end else if (n > 0) begin
        burst[n - 1].last = 1'b1;
      end else begin
        burst[0] = '{req.px, req.py, 8'h00, 8'h00, 1'b1, 3'd0};
        n = 1;
      end
    end
    for (int i = 0; i < n; i++) expected_writes.push_back(burst[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on %s at write %0d: got %0h, want %0h", what, writes_checked, got,
             want);
    mismatch_count++;
  endtask

  // Check each write against the oldest prediction, then log a taken request
  always @(posedge clk_i) begin : write_check
    col_write_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected write x", column_x_o, 16'h0);
        end else begin
          want = expected_writes.pop_front();
          if (column_x_o !== want.column_x)
            report_mismatch("column_x", column_x_o, want.column_x);
          if (top_y_o !== want.top_y)
            report_mismatch("top_y", top_y_o, want.top_y);
          if (row_bits_o !== want.row_bits)
            report_mismatch("row_bits", 16'(row_bits_o), 16'(want.row_bits));
          if (row_write_mask_o !== want.row_write_mask)
            report_mismatch("row_write_mask", 16'(row_write_mask_o),
                            16'(want.row_write_mask));
          if (last_o !== want.last)
            report_mismatch("last", 16'(last_o), 16'(want.last));
          if (char_width_o !== want.char_width)
            report_mismatch("char_width", 16'(char_width_o), 16'(want.char_width));
        end
        writes_checked++;
      end
      if (start_i && !busy_o) begin
        predict_columns('{char_code_i, font_mode_i, pos_x_i, pos_y_i});
        requests_taken++;
      end
    end
  end

  // Abort when neither a request nor a write moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic glyph_req_t glyph(input logic [7:0] code, input logic [1:0] mode,
                                       input logic [15:0] px, input logic [15:0] py);
    return '{code, mode, px, py};
  endfunction

  function automatic glyph_req_t random_glyph();
    glyph_req_t req;
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) req.code = 8'($urandom_range(32, 131));
    else if (sel < 75) req.code = FOLDED_CODES[$urandom_range(6)];
    else req.code = 8'($urandom);
    req.mode = 2'($urandom_range(3));
    sel = $urandom_range(99);
    if (sel < 15) req.px = 16'($urandom_range(65525, 65535));
    else if (sel < 20) req.px = 16'($urandom_range(7));
    else req.px = 16'($urandom);
    req.py = 16'($urandom);
    return req;
  endfunction

  // Present one request, idling with junk on the fields first when gaps are on
  task automatic send_glyph(input glyph_req_t req);
    while (gaps_on && $urandom_range(99) < 34) begin
      @(negedge clk_i);
      start_i     <= 1'b0;
      char_code_i <= 8'($urandom);
      font_mode_i <= 2'($urandom);
      pos_x_i     <= 16'($urandom);
      pos_y_i     <= 16'($urandom);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    char_code_i <= req.code;
    font_mode_i <= req.mode;
    pos_x_i     <= req.px;
    pos_y_i     <= req.py;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Hold off new requests until every predicted write has come out
  task automatic hold_until_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_outside_font();
    send_glyph(glyph(8'd0, FM_PROP, 16'd0, 16'd0));
    send_glyph(glyph(8'd255, FM_FIXED_UL, 16'hFFFF, 16'hFFFF));
    send_glyph(glyph(CH_BELOW_FONT, FM_PROP_UL, 16'd1234, 16'd7));
    send_glyph(glyph(CH_PAST_FONT, FM_FIXED, 16'd40, 16'd0));
  endtask

  task automatic test_font_edges();
    send_glyph(glyph(CH_SPACE, FM_PROP, 16'hFFFF, 16'h8000));
    send_glyph(glyph(CH_SPACE, FM_FIXED, 16'd100, 16'd200));
    send_glyph(glyph(CH_DEL, FM_FIXED, 16'd5, 16'd5));
    send_glyph(glyph(CH_TOP_GLYPH, FM_PROP, 16'd0, 16'hFFFF));
  endtask

  task automatic test_folded_codes();
    for (int i = 0; i < 7; i++)
      send_glyph(glyph(FOLDED_CODES[i], 2'(i), 16'(i * 9), 16'(i * 3 + 1)));
  endtask

  task automatic test_thinning();
    send_glyph(glyph(CH_DASH, FM_PROP, 16'd10, 16'd10));
    send_glyph(glyph(CH_DASH, FM_PROP_UL, 16'd20, 16'd20));
    send_glyph(glyph(CH_A, FM_PROP, 16'd30, 16'hFFFF));
    send_glyph(glyph(CH_EXCL, FM_PROP, 16'hFFFE, 16'd3));
  endtask

  // Positions near the top of the coordinate range cut the glyph short
  task automatic test_coord_limit();
    send_glyph(glyph(CH_H, FM_FIXED_UL, 16'hFFFB, 16'd1));
    send_glyph(glyph(CH_M, FM_FIXED, 16'hFFFD, 16'd2));
    send_glyph(glyph(CH_W, FM_PROP_UL, 16'hFFFF, 16'd3));
    send_glyph(glyph(CH_B, FM_PROP, 16'hFFFF, 16'd4));
    send_glyph(glyph(CODE_SHARP_S, FM_FIXED_UL, 16'hFFFF, 16'd5));
  endtask

  task automatic test_random_traffic(input int count);
    gaps_on = 1'b1;
    for (int i = 0; i < count; i++) send_glyph(random_glyph());
  endtask

  task automatic test_drain_pause();
    hold_until_drained();
    send_glyph(random_glyph());
    send_glyph(random_glyph());
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    for (int i = 0; i < count; i++) send_glyph(random_glyph());
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_outside_font();
    test_font_edges();
    test_folded_codes();
    test_thinning();
    test_coord_limit();
    test_random_traffic(126);
    test_drain_pause();
    test_back_to_back(68);

    // Let the last writes out and watch for strays
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d character requests (font edges, folded codes, thinning, limit, random)",
             requests_taken);
    $display("checked %0d column writes, %0d mismatches", writes_checked, mismatch_count);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
